// File: sv/ljpeg_pkg.sv
// ----------------------------------------------------------------------------
// ljpeg_pkg
// Shared types and constants for the Lennard-Jones pair energy and gradient
// unit: micro-operation codes, controller/datapath signal groups, limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ljpeg_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [63:0] MAXV      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAXV_DIV12 = MAXV / 64'd12;
    localparam logic [30:0] BOX_MAX   = 31'h7FFF_FFFF;
    localparam logic [63:0] S_ONE     = 64'h0000_0001_0000_0000;
    localparam logic [63:0] S_TWO     = 64'h0000_0002_0000_0000;

    localparam logic [7:0] NBITS_WRAP = 8'd34;
    localparam logic [7:0] NBITS_U    = 8'd74;
    localparam logic [7:0] NBITS_G    = 8'd128;

    localparam logic [1:0] REG_BOX_X = 2'd0;
    localparam logic [1:0] REG_BOX_Y = 2'd1;
    localparam logic [1:0] REG_BOX_Z = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_WDIV,
        OP_WMUL,
        OP_WFIX,
        OP_SQACC,
        OP_A1,
        OP_A2,
        OP_SIG,
        OP_UDIV,
        OP_U2,
        OP_S3,
        OP_BM,
        OP_EM,
        OP_ECAP,
        OP_GSKIP,
        OP_GM,
        OP_GDIV,
        OP_GF,
        OP_GCAP,
        OP_GSAT,
        OP_FAIL,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic div_ovf;
        logic prod_ovf;
        logic b_ovf;
        logic r2_zero;
        logic a_zero;
        logic g_skip;
        logic k_last;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: sv/ljpeg_mul.sv
// ----------------------------------------------------------------------------
// ljpeg_mul
// Iterative 64 x 64 multiplier built from one 32 x 32 multiplier; four
// partial products are accumulated into a 128-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module ljpeg_mul
    import ljpeg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      p
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp;
    logic [127:0] addend;

    always_comb
    begin
        ah = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        bh = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp = ah * bh;
        case (cnt_reg)
            2'd0:    addend = {64'd0, pp};
            2'd3:    addend = {pp, 64'd0};
            default: addend = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + addend;
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// File: sv/ljpeg_div.sv
// ----------------------------------------------------------------------------
// ljpeg_div
// Bit-serial restoring divider: 128-bit numerator, 64-bit divisor, one
// quotient bit per cycle, with a flag for quotients of 2^63 and above.
// ----------------------------------------------------------------------------
`default_nettype none

module ljpeg_div
    import ljpeg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    input  wire logic [7:0]   nbits,
    output logic              done,
    output logic [63:0]       q,
    output logic              ovf
);

    logic [127:0] num_reg;
    logic [63:0]  den_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         qovf_reg;
    logic [7:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  trial;
    logic         ge;

    always_comb
    begin
        trial = {rem_reg[62:0], num_reg[127]};
        ge    = (trial >= den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
                qovf_reg <= 1'b0;
                cnt_reg  <= nbits;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg  <= {num_reg[126:0], 1'b0};
                rem_reg  <= ge ? (trial - den_reg) : trial;
                q_reg    <= {q_reg[62:0], ge};
                qovf_reg <= qovf_reg | q_reg[63];
                cnt_reg  <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign ovf  = qovf_reg | q_reg[63];

endmodule

`default_nettype wire

// File: sv/ljpeg_dp.sv
// ----------------------------------------------------------------------------
// ljpeg_dp
// Datapath: box registers, pair operands, shared multiplier and divider,
// intermediate values, energy accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ljpeg_dp
    import ljpeg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    input  wire logic signed [31:0] first_x,
    input  wire logic signed [31:0] first_y,
    input  wire logic signed [31:0] first_z,
    input  wire logic signed [31:0] second_x,
    input  wire logic signed [31:0] second_y,
    input  wire logic signed [31:0] second_z,
    input  wire logic [19:0]        first_eps,
    input  wire logic [19:0]        second_eps,
    input  wire logic [19:0]        first_rmin,
    input  wire logic [19:0]        second_rmin,
    input  wire logic [16:0]        pair_scale,
    input  wire logic               last_pair,
    input  wire cmd_t               cmd,
    output status_t                 st,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      grad_x,
    output logic signed [63:0]      grad_y,
    output logic signed [63:0]      grad_z,
    output logic signed [63:0]      energy_total,
    output logic                    total_final,
    output logic                    overflow
);

    localparam int BSH = 2 * FRAC_BITS + 16;

    logic [30:0]        box_reg [3];
    logic signed [33:0] d_reg [3];
    logic signed [33:0] w_reg [3];
    logic signed [63:0] grad_reg [3];
    logic [19:0]        eps_a_reg;
    logic [19:0]        eps_b_reg;
    logic [20:0]        sigma_reg;
    logic [16:0]        scale_reg;
    logic               last_reg;
    logic [1:0]         k_reg;
    logic [63:0]        r2_reg;
    logic [56:0]        a_reg;
    logic [63:0]        u_reg;
    logic [63:0]        s_reg;
    logic [63:0]        b_reg;
    logic               ok_reg;
    logic signed [63:0] epair_reg;
    logic signed [63:0] esum_reg;
    logic               ovf_seen_reg;
    logic               out_valid_reg;
    logic signed [63:0] out_grad_reg [3];
    logic signed [63:0] out_energy_reg;
    logic               out_final_reg;
    logic               out_ovf_reg;

    logic               mul_start;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic               mul_done;
    logic [127:0]       prod;
    logic               div_start;
    logic [127:0]       div_num;
    logic [63:0]        div_den;
    logic [7:0]         div_nbits;
    logic               div_done;
    logic [63:0]        div_q;
    logic               div_ovf;

    logic [30:0]        box_k;
    logic [30:0]        box_eff;
    logic signed [33:0] d_k;
    logic [33:0]        d_mag;
    logic [33:0]        wrap_num;
    logic signed [33:0] w_new;
    logic [33:0]        w_new_mag;
    logic signed [33:0] w_k;
    logic [33:0]        wm_k;
    logic [63:0]        t;
    logic [63:0]        b_new;
    logic [63:0]        s_m2;
    logic [63:0]        s_m1;
    logic               g_neg;
    logic               e_neg;
    logic               prod_ovf;
    logic               b_ovf;
    logic               g_fit;
    logic [63:0]        mag12;
    logic signed [63:0] ep_f;
    logic signed [63:0] grad_f [3];
    logic               ovf_f;
    logic signed [64:0] sum65;
    logic signed [63:0] sum_f;
    logic               sum_sat;

    ljpeg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (prod)
    );

    ljpeg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .nbits (div_nbits),
        .done  (div_done),
        .q     (div_q),
        .ovf   (div_ovf)
    );

    always_comb
    begin
        box_k     = box_reg[k_reg];
        box_eff   = (box_k == 31'd0) ? BOX_MAX : box_k;
        d_k       = d_reg[k_reg];
        d_mag     = d_k[33] ? 34'(-d_k) : 34'(d_k);
        wrap_num  = {d_mag[32:0], 1'b0} + {3'd0, box_eff};
        w_new     = d_k[33] ? (d_k + signed'(prod[33:0])) : (d_k - signed'(prod[33:0]));
        w_new_mag = w_new[33] ? 34'(-w_new) : 34'(w_new);
        w_k       = w_reg[k_reg];
        wm_k      = w_k[33] ? 34'(-w_k) : 34'(w_k);
        t         = prod[95:32];
        b_new     = prod[BSH +: 64];
        s_m2      = (s_reg >= S_TWO) ? (s_reg - S_TWO) : (S_TWO - s_reg);
        s_m1      = (s_reg >= S_ONE) ? (s_reg - S_ONE) : (S_ONE - s_reg);
        e_neg     = (s_reg < S_TWO);
        g_neg     = ((s_reg < S_ONE) == w_k[33]);
        prod_ovf  = |prod[127:95];
        b_ovf     = ((prod >> (BSH + 63)) != 128'd0);
        g_fit     = (prod[127:96] == 32'd0) && (t <= MAXV_DIV12);
        mag12     = {t[60:0], 3'd0} + {t[61:0], 2'd0};
    end

    always_comb
    begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (cmd.op)
            OP_WMUL:
            begin
                mul_a = div_q;
                mul_b = {33'd0, box_eff};
            end
            OP_WFIX:
            begin
                mul_a = {30'd0, w_new_mag};
                mul_b = {30'd0, w_new_mag};
            end
            OP_A1:
            begin
                mul_a = {44'd0, eps_a_reg};
                mul_b = {44'd0, eps_b_reg};
            end
            OP_A2:
            begin
                mul_a = {24'd0, prod[39:0]};
                mul_b = {47'd0, scale_reg};
            end
            OP_SIG:
            begin
                mul_a = {43'd0, sigma_reg};
                mul_b = {43'd0, sigma_reg};
            end
            OP_U2:
            begin
                mul_a = div_q;
                mul_b = div_q;
            end
            OP_S3:
            begin
                mul_a = t;
                mul_b = u_reg;
            end
            OP_BM:
            begin
                mul_a = {7'd0, a_reg};
                mul_b = t;
            end
            OP_EM:
            begin
                mul_a = b_new;
                mul_b = s_m2;
            end
            OP_GM:
            begin
                mul_a = b_reg;
                mul_b = {30'd0, wm_k};
            end
            OP_GF:
            begin
                mul_a = div_q;
                mul_b = s_m1;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        div_nbits = NBITS_G;
        case (cmd.op)
            OP_WDIV:
            begin
                div_num   = {wrap_num, 94'd0};
                div_den   = {32'd0, box_eff, 1'b0};
                div_nbits = NBITS_WRAP;
            end
            OP_UDIV:
            begin
                div_num   = {prod[41:0], 86'd0};
                div_den   = r2_reg;
                div_nbits = NBITS_U;
            end
            OP_GDIV:
            begin
                div_num   = prod << FRAC_BITS;
                div_den   = r2_reg;
                div_nbits = NBITS_G;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ep_f  = ok_reg ? epair_reg : signed'(MAXV);
        ovf_f = ovf_seen_reg | ~ok_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (ok_reg)
                grad_f[i] = grad_reg[i];
            else if (w_reg[i][33])
                grad_f[i] = signed'(MAXV);
            else if (w_reg[i] != 34'sd0)
                grad_f[i] = -signed'(MAXV);
            else
                grad_f[i] = 64'sd0;
        end
        sum65   = 65'(esum_reg) + 65'(ep_f);
        sum_sat = 1'b1;
        if (sum65 > 65'sd9223372036854775807)
            sum_f = signed'(MAXV);
        else if (sum65 < -65'sd9223372036854775807)
            sum_f = -signed'(MAXV);
        else
        begin
            sum_f   = sum65[63:0];
            sum_sat = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_reg[i]      <= BOX_MAX;
                d_reg[i]        <= '0;
                w_reg[i]        <= '0;
                grad_reg[i]     <= '0;
                out_grad_reg[i] <= '0;
            end
            eps_a_reg      <= '0;
            eps_b_reg      <= '0;
            sigma_reg      <= '0;
            scale_reg      <= '0;
            last_reg       <= 1'b0;
            k_reg          <= '0;
            r2_reg         <= '0;
            a_reg          <= '0;
            u_reg          <= '0;
            s_reg          <= '0;
            b_reg          <= '0;
            ok_reg         <= 1'b1;
            epair_reg      <= '0;
            esum_reg       <= '0;
            ovf_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_energy_reg <= '0;
            out_final_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BOX_X: box_reg[0] <= cfg_data;
                    REG_BOX_Y: box_reg[1] <= cfg_data;
                    REG_BOX_Z: box_reg[2] <= cfg_data;
                    default:   ;
                endcase
            end

            if (cmd.op == OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                OP_LOAD:
                begin
                    d_reg[0]  <= 34'(first_x) - 34'(second_x);
                    d_reg[1]  <= 34'(first_y) - 34'(second_y);
                    d_reg[2]  <= 34'(first_z) - 34'(second_z);
                    eps_a_reg <= first_eps;
                    eps_b_reg <= second_eps;
                    sigma_reg <= {1'b0, first_rmin} + {1'b0, second_rmin};
                    scale_reg <= pair_scale;
                    last_reg  <= last_pair;
                    k_reg     <= '0;
                    r2_reg    <= '0;
                    ok_reg    <= 1'b1;
                    epair_reg <= '0;
                    for (int i = 0; i < 3; i++)
                        grad_reg[i] <= '0;
                end
                OP_WFIX:
                begin
                    w_reg[k_reg] <= w_new;
                end
                OP_SQACC:
                begin
                    r2_reg <= r2_reg + prod[63:0];
                    k_reg  <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                OP_SIG:
                begin
                    a_reg <= prod[56:0];
                end
                OP_U2:
                begin
                    u_reg <= div_q;
                end
                OP_BM:
                begin
                    s_reg <= t;
                end
                OP_EM:
                begin
                    b_reg <= b_new;
                end
                OP_ECAP:
                begin
                    if (prod_ovf)
                    begin
                        epair_reg    <= e_neg ? -signed'(MAXV) : signed'(MAXV);
                        ovf_seen_reg <= 1'b1;
                    end
                    else
                    begin
                        epair_reg <= e_neg ? -signed'(t) : signed'(t);
                    end
                    k_reg <= '0;
                end
                OP_GSKIP:
                begin
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                OP_GSAT:
                begin
                    grad_reg[k_reg] <= g_neg ? -signed'(MAXV) : signed'(MAXV);
                    ovf_seen_reg    <= 1'b1;
                    k_reg           <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                OP_GCAP:
                begin
                    if (g_fit)
                        grad_reg[k_reg] <= g_neg ? -signed'(mag12) : signed'(mag12);
                    else
                    begin
                        grad_reg[k_reg] <= g_neg ? -signed'(MAXV) : signed'(MAXV);
                        ovf_seen_reg    <= 1'b1;
                    end
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                OP_FAIL:
                begin
                    ok_reg <= 1'b0;
                end
                OP_FINISH:
                begin
                    for (int i = 0; i < 3; i++)
                        out_grad_reg[i] <= grad_f[i];
                    out_energy_reg <= sum_f;
                    out_final_reg  <= last_reg;
                    out_ovf_reg    <= ovf_f | sum_sat;
                    if (last_reg)
                    begin
                        esum_reg     <= '0;
                        ovf_seen_reg <= 1'b0;
                    end
                    else
                    begin
                        esum_reg     <= sum_f;
                        ovf_seen_reg <= ovf_f | sum_sat;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        st.mul_done = mul_done;
        st.div_done = div_done;
        st.div_ovf  = div_ovf;
        st.prod_ovf = prod_ovf;
        st.b_ovf    = b_ovf;
        st.r2_zero  = (r2_reg == 64'd0);
        st.a_zero   = (prod[56:0] == 57'd0);
        st.g_skip   = (wm_k == 34'd0) || (s_reg == S_ONE);
        st.k_last   = (k_reg == 2'd2);
        st.out_busy = out_valid_reg & out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign grad_x       = out_grad_reg[0];
    assign grad_y       = out_grad_reg[1];
    assign grad_z       = out_grad_reg[2];
    assign energy_total = out_energy_reg;
    assign total_final  = out_final_reg;
    assign overflow     = out_ovf_reg;

endmodule

`default_nettype wire

// File: sv/ljpeg_ctrl.sv
// ----------------------------------------------------------------------------
// ljpeg_ctrl
// Controller: sequences the micro-operations of one pair through the shared
// multiplier and divider and branches on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module ljpeg_ctrl
    import ljpeg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t st,
    output cmd_t         cmd
);

    typedef enum logic [18:0] {
        S_IDLE    = 19'd1,
        S_AX_DIV  = 19'd2,
        S_AX_DIVW = 19'd4,
        S_AX_MULW = 19'd8,
        S_AX_SQW  = 19'd16,
        S_PRE     = 19'd32,
        S_A1W     = 19'd64,
        S_A2W     = 19'd128,
        S_SIGW    = 19'd256,
        S_UDIVW   = 19'd512,
        S_U2W     = 19'd1024,
        S_SW      = 19'd2048,
        S_BW      = 19'd4096,
        S_EW      = 19'd8192,
        S_GCHK    = 19'd16384,
        S_GMW     = 19'd32768,
        S_GDW     = 19'd65536,
        S_GFW     = 19'd131072,
        S_FIN     = 19'd262144
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_AX_DIV;
                end
            end
            S_AX_DIV:
            begin
                cmd.op     = OP_WDIV;
                state_next = S_AX_DIVW;
            end
            S_AX_DIVW:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_WMUL;
                    state_next = S_AX_MULW;
                end
            end
            S_AX_MULW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_WFIX;
                    state_next = S_AX_SQW;
                end
            end
            S_AX_SQW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_SQACC;
                    state_next = st.k_last ? S_PRE : S_AX_DIV;
                end
            end
            S_PRE:
            begin
                if (st.r2_zero)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_A1;
                    state_next = S_A1W;
                end
            end
            S_A1W:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_A2;
                    state_next = S_A2W;
                end
            end
            S_A2W:
            begin
                if (st.mul_done)
                begin
                    if (st.a_zero)
                        state_next = S_FIN;
                    else
                    begin
                        cmd.op     = OP_SIG;
                        state_next = S_SIGW;
                    end
                end
            end
            S_SIGW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_UDIV;
                    state_next = S_UDIVW;
                end
            end
            S_UDIVW:
            begin
                if (st.div_done)
                begin
                    cmd.op     = st.div_ovf ? OP_FAIL : OP_U2;
                    state_next = st.div_ovf ? S_FIN : S_U2W;
                end
            end
            S_U2W:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = st.prod_ovf ? OP_FAIL : OP_S3;
                    state_next = st.prod_ovf ? S_FIN : S_SW;
                end
            end
            S_SW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = st.prod_ovf ? OP_FAIL : OP_BM;
                    state_next = st.prod_ovf ? S_FIN : S_BW;
                end
            end
            S_BW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = st.b_ovf ? OP_FAIL : OP_EM;
                    state_next = st.b_ovf ? S_FIN : S_EW;
                end
            end
            S_EW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_ECAP;
                    state_next = S_GCHK;
                end
            end
            S_GCHK:
            begin
                if (st.g_skip)
                begin
                    cmd.op     = OP_GSKIP;
                    state_next = st.k_last ? S_FIN : S_GCHK;
                end
                else
                begin
                    cmd.op     = OP_GM;
                    state_next = S_GMW;
                end
            end
            S_GMW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_GDIV;
                    state_next = S_GDW;
                end
            end
            S_GDW:
            begin
                if (st.div_done)
                begin
                    if (st.div_ovf)
                    begin
                        cmd.op     = OP_GSAT;
                        state_next = st.k_last ? S_FIN : S_GCHK;
                    end
                    else
                    begin
                        cmd.op     = OP_GF;
                        state_next = S_GFW;
                    end
                end
            end
            S_GFW:
            begin
                if (st.mul_done)
                begin
                    cmd.op     = OP_GCAP;
                    state_next = st.k_last ? S_FIN : S_GCHK;
                end
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: sv/lj_pair_energy_gradient_unit.sv
// ----------------------------------------------------------------------------
// lj_pair_energy_gradient_unit
// Lennard-Jones 12-6 pair energy and first-atom gradient with minimum image
// wrapping and a saturating per-list energy sum.
//
//   Channel   Direction   Handshake                Contents
//   cfg       in          cfg_write                box_x, box_y, box_z
//   in        in          in_valid / in_stall      one atom pair
//   out       out         out_valid / out_stall    gradient, energy sum, flags
//
// A pair's work runs through the bit-serial divider (34 steps per axis wrap,
// 74 for the distance ratio, 128 per gradient axis) and the shared multiplier,
// and ends early at zero distance or zero strength. Reset clears the energy
// sum, the overflow flag and the box lengths to their largest value. A stalled
// result holds the next pair at its last step; a new pair may be transferred
// while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lj_pair_energy_gradient_unit
    import ljpeg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] first_x,
    input  wire logic signed [31:0] first_y,
    input  wire logic signed [31:0] first_z,
    input  wire logic signed [31:0] second_x,
    input  wire logic signed [31:0] second_y,
    input  wire logic signed [31:0] second_z,
    input  wire logic [19:0]        first_eps,
    input  wire logic [19:0]        second_eps,
    input  wire logic [19:0]        first_rmin,
    input  wire logic [19:0]        second_rmin,
    input  wire logic [16:0]        pair_scale,
    input  wire logic               last_pair,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      grad_x,
    output logic signed [63:0]      grad_y,
    output logic signed [63:0]      grad_z,
    output logic signed [63:0]      energy_total,
    output logic                    total_final,
    output logic                    overflow
);

    cmd_t    cmd;
    status_t st;

    ljpeg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ljpeg_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .first_eps    (first_eps),
        .second_eps   (second_eps),
        .first_rmin   (first_rmin),
        .second_rmin  (second_rmin),
        .pair_scale   (pair_scale),
        .last_pair    (last_pair),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z),
        .energy_total (energy_total),
        .total_final  (total_final),
        .overflow     (overflow)
    );

    // A transferred pair keeps the input side busy on the next cycle.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after a pair transfer");

    // A new result only appears at the end of a pair's work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a pair in progress");

    // The shared multiplier and divider never finish in the same cycle.
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(st.mul_done && st.div_done))
        else $error("multiplier and divider finished together");

endmodule

`default_nettype wire
